// ----- rtl/core/csfp_pkg.sv -----
package csfp_pkg;

  // Header bytes that open a status frame
  localparam logic [7:0] HDR_FIRST  = 8'hFF;
  localparam logic [7:0] HDR_SECOND = 8'hFE;

  // Payload: speed A, dir A, speed B, dir B, speed C, dir C, speed D, dir D,
  // gyro high, gyro low
  localparam int unsigned PAYLOAD_LEN = 10;
  localparam int unsigned STORE_DEPTH = PAYLOAD_LEN - 1;
  localparam int unsigned IDX_W       = $clog2(PAYLOAD_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_LEN - 1);

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SPEED_W = 9;
  localparam int unsigned GYRO_W  = 16;
  localparam int unsigned OUT_DATA_W = 56;  // 4 x 9 + 16 = 52, padded to bytes

  // Wheel direction codes
  localparam logic [7:0] DIR_FWD  = 8'd0;
  localparam logic [7:0] DIR_STOP = 8'd1;
  localparam logic [7:0] DIR_REV  = 8'd2;

  // Frame sync phase
  typedef enum logic [1:0] {
    PH_HUNT,   // looking for first header byte
    PH_HDR2,   // seen 0xFF, waiting for 0xFE
    PH_DATA    // collecting payload bytes
  } phase_t;

  typedef logic signed [SPEED_W-1:0] speed_t;

  typedef struct packed {
    speed_t speed;
    logic   fault;
  } wheel_t;

  // Decode one wheel: magnitude byte plus direction code
  function automatic wheel_t wheel_decode(input logic [7:0] mag, input logic [7:0] code);
    wheel_t w;
    w.fault = 1'b0;
    case (code)
      DIR_FWD:  w.speed = speed_t'({1'b0, mag});
      DIR_STOP: w.speed = '0;
      DIR_REV:  w.speed = speed_t'(-{1'b0, mag});
      default: begin
        w.speed = '0;
        w.fault = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/chassis_status_frame_parser_top.sv -----
// Channel | Dir | Ports                          | Item
// in      | in  | in_tvalid/in_tready/in_tdata   | one received serial byte
// out     | out | out_tvalid/out_tready/out_tdata| one decoded status record
//                 out_tuser                      | direction fault flag
//
// Each byte is registered on entry and handled from the input register; one
// byte per cycle is sustained while the output is not stalled. A record is
// decoded as the last payload byte leaves the input register and is held
// in the result register, which drives out. Synchronous active-low reset
// returns the parser to the header hunt and empties both registers; the
// payload store is not cleared. A stalled output holds the record and the
// input register absorbs one more byte before in_tready drops.
module chassis_status_frame_parser_top
  import csfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [8:0] wheel_a_speed, [17:9] wheel_b_speed, [26:18] wheel_c_speed,
  // [35:27] wheel_d_speed, [51:36] gyro_rate, [55:52] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser   // [0] direction_fault
);

  // Input register
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             advance;

  // Parser state
  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       store_r [STORE_DEPTH];
  logic             store_we;
  logic             emit;

  // Result register
  logic             out_valid_r;
  speed_t           spd_a_r, spd_b_r, spd_c_r, spd_d_r;
  logic [GYRO_W-1:0] gyro_r;
  logic             fault_r;

  wheel_t           w_a, w_b, w_c, w_d;
  logic [GYRO_W-1:0] gyro_nxt;

  // Byte in the input register moves on when the result slot is free
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    if (advance) begin
      case (phase_r)
        PH_HUNT: begin
          phase_nxt = (s1_byte_r == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
        end
        PH_HDR2: begin
          if (s1_byte_r == HDR_SECOND) begin
            phase_nxt = PH_DATA;
            idx_nxt   = '0;
          end else if (s1_byte_r == HDR_FIRST) begin
            phase_nxt = PH_HDR2;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (idx_r == IDX_LAST) begin
            phase_nxt = PH_HUNT;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          idx_nxt   = '0;
        end
      endcase
    end
  end

  // Phase outputs: store strobe and record strobe
  always_comb begin
    store_we = 1'b0;
    emit     = 1'b0;
    case (phase_r)
      PH_DATA: begin
        store_we = advance && (idx_r != IDX_LAST);
        emit     = advance && (idx_r == IDX_LAST);
      end
      default: begin
        store_we = 1'b0;
        emit     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Payload store
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[idx_r] <= s1_byte_r;
    end
  end

  // Record decode
  assign w_a = wheel_decode(store_r[0], store_r[1]);
  assign w_b = wheel_decode(store_r[2], store_r[3]);
  assign w_c = wheel_decode(store_r[4], store_r[5]);
  assign w_d = wheel_decode(store_r[6], store_r[7]);
  // word - 32768 modulo 2^16 is the word with its top bit flipped
  assign gyro_nxt = {~store_r[8][7], store_r[8][6:0], s1_byte_r};

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      spd_a_r <= w_a.speed;
      spd_b_r <= w_b.speed;
      spd_c_r <= w_c.speed;
      spd_d_r <= w_d.speed;
      gyro_r  <= gyro_nxt;
      fault_r <= w_a.fault | w_b.fault | w_c.fault | w_d.fault;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, gyro_r, spd_d_r, spd_c_r, spd_b_r, spd_a_r};
  assign out_tuser  = fault_r;

  // Checks

  // Payload index never runs past the last payload byte
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("payload index out of range");

  // Index is parked at zero outside the payload phase
  a_idx_park: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_DATA |-> idx_r == '0)
    else $error("payload index not cleared outside frame");

  // A new record follows only the last payload byte
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r && $past(phase_r == PH_DATA && idx_r == IDX_LAST))
    else $error("record emitted from wrong phase");

  // Input stalls only when both registers are full and the output is held
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without cause");

endmodule

// ----- verif/csfp_frame_checker.sv -----
module csfp_frame_checker
  import csfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // [8:0] wheel_a_speed, [17:9] wheel_b_speed, [26:18] wheel_c_speed,
  // [35:27] wheel_d_speed, [51:36] gyro_rate, [55:52] zero
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,  // [0] direction_fault
  output int                    errors,
  output int                    records_due
);

  localparam logic [GYRO_W-1:0] GYRO_BIAS = 16'h8000;

  typedef struct packed {
    speed_t                    speed_a;
    speed_t                    speed_b;
    speed_t                    speed_c;
    speed_t                    speed_d;
    logic signed [GYRO_W-1:0]  gyro;
    logic                      fault;
  } status_rec_t;

  // Parser state as seen by the predictor
  phase_t           sync_phase;
  logic [IDX_W-1:0] byte_idx;
  logic [7:0]       payload [STORE_DEPTH];
  status_rec_t      rec_due_q [$];
  int               mismatch_cnt = 0;

  // Signed wheel speed from magnitude and direction code; unknown code flags a fault
  function automatic speed_t wheel_speed(input logic [7:0] mag, input logic [7:0] code,
                                         inout logic fault);
    if (code == DIR_FWD) return speed_t'({1'b0, mag});
    if (code == DIR_STOP) return '0;
    if (code == DIR_REV) return 9'd0 - {1'b0, mag};
    fault = 1'b1;
    return '0;
  endfunction

  task automatic compare_field(input string fld, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    status_rec_t want;
    logic        flt;
    if (!rst_n) begin
      sync_phase = PH_HUNT;
      byte_idx   = '0;
      rec_due_q.delete();
    end else begin
      // input side: advance the header hunt / payload capture
      if (in_tvalid && in_tready) begin
        case (sync_phase)
          PH_HDR2: begin
            sync_phase = (in_tdata == HDR_SECOND) ? PH_DATA :
                         (in_tdata == HDR_FIRST)  ? PH_HDR2 : PH_HUNT;
            byte_idx = '0;
          end
          PH_DATA: begin
            if (byte_idx != IDX_LAST) begin
              payload[byte_idx] = in_tdata;
              byte_idx = byte_idx + 1'b1;
            end else begin
              flt          = 1'b0;
              want.speed_a = wheel_speed(payload[0], payload[1], flt);
              want.speed_b = wheel_speed(payload[2], payload[3], flt);
              want.speed_c = wheel_speed(payload[4], payload[5], flt);
              want.speed_d = wheel_speed(payload[6], payload[7], flt);
              want.gyro    = {payload[8], in_tdata} - GYRO_BIAS;
              want.fault   = flt;
              rec_due_q.push_back(want);
              sync_phase = PH_HUNT;
            end
          end
          default: sync_phase = (in_tdata == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
        endcase
      end

      // output side: compare against the oldest outstanding record
      if (out_tvalid && out_tready) begin
        if (rec_due_q.size() == 0) begin
          $display("%0t: record with none outstanding, expected nothing, actual %h/%b",
                   $time, out_tdata, out_tuser);
          mismatch_cnt++;
        end else begin
          want = rec_due_q.pop_front();
          compare_field("wheel_a_speed", want.speed_a, $signed(out_tdata[8:0]));
          compare_field("wheel_b_speed", want.speed_b, $signed(out_tdata[17:9]));
          compare_field("wheel_c_speed", want.speed_c, $signed(out_tdata[26:18]));
          compare_field("wheel_d_speed", want.speed_d, $signed(out_tdata[35:27]));
          compare_field("gyro_rate", want.gyro, $signed(out_tdata[51:36]));
          compare_field("pad", 0, $signed({1'b0, out_tdata[55:52]}));
          compare_field("direction_fault", want.fault, $signed({1'b0, out_tuser}));
        end
      end
    end
    errors      <= mismatch_cnt;
    records_due <= rec_due_q.size();
  end

endmodule

// ----- verif/tb_chassis_status_frame_parser_top.sv -----
module tb_chassis_status_frame_parser_top
  import csfp_pkg::*;
;

  localparam int ITEM_TARGET  = 1050;
  localparam int QUIET_TAIL   = 150;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;   // [7:0] rx_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [8:0] wheel_a_speed, [17:9] wheel_b_speed, [26:18] wheel_c_speed,
  // [35:27] wheel_d_speed, [51:36] gyro_rate, [55:52] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;         // [0] direction_fault

  int errors;
  int records_due;
  bit pace_on     = 1'b0;
  bit stall_on    = 1'b0;
  int stall_left  = 0;
  int quiet_cycles = 0;
  int bytes_sent  = 0;

  chassis_status_frame_parser_top DUT (.*);

  csfp_frame_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stall bursts while enabled
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("chassis_status_frame_parser_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Payload byte biased towards the extremes and the header values
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return HDR_FIRST;
      2:       return HDR_SECOND;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one byte, optionally after a random gap, and wait for acceptance
  task automatic push_byte(input logic [7:0] b);
    if (pace_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  initial begin
    logic [7:0] opening [28] = '{
      // repeated first header byte, then speeds at the extremes, an
      // out-of-range code, header bytes as data and gyro at full scale
      8'hFF, 8'hFF, 8'hFE,
      8'hFF, DIR_FWD, 8'h00, DIR_STOP, 8'h80, DIR_REV, 8'h12, 8'h03, 8'hFF, 8'hFF,
      // broken header; the breaking byte is not a new start
      8'hFF, 8'h55, 8'hFE,
      // reverse at full scale, code 0xFF, gyro at the negative limit
      8'hFF, 8'hFE,
      8'hFF, DIR_REV, 8'hFE, 8'hFF, 8'hFE, DIR_FWD, 8'h01, DIR_REV, 8'h00, 8'h00
    };
    int         seq_cnt;
    int         n;
    logic [7:0] code;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening
    pace_on   = 1'b1;
    stall_on <= 1'b1;
    foreach (opening[i]) push_byte(opening[i]);

    // random frames, noise and broken headers
    seq_cnt = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent >= ITEM_TARGET - QUIET_TAIL) begin
        pace_on   = 1'b0;
        stall_on <= 1'b0;
      end else if (seq_cnt % 8 == 0) begin
        n         = $urandom_range(0, 3);
        pace_on   = n[0];
        stall_on <= n[1];
      end
      seq_cnt++;
      n = $urandom_range(0, 9);
      if (n < 7) begin
        // well-formed frame, sometimes with extra leading 0xFF
        push_byte(HDR_FIRST);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        repeat (4) begin
          push_byte(pick_byte());
          n    = $urandom_range(0, 15);
          code = (n < 4)   ? DIR_FWD :
                 (n < 8)   ? DIR_STOP :
                 (n < 12)  ? DIR_REV :
                 (n == 15) ? 8'hFF : 8'($urandom_range(3, 254));
          push_byte(code);
        end
        push_byte(pick_byte());
        push_byte(pick_byte());
      end else if (n < 9) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_byte(HDR_FIRST);
        push_byte(8'($urandom_range(0, 253)));
      end
    end
    in_tvalid <= 1'b0;

    // drain outstanding records, then allow for pipeline latency
    do @(posedge clk); while (records_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && records_due == 0) begin
      $display("chassis_status_frame_parser_top regression: pass");
    end else begin
      $display("chassis_status_frame_parser_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- chassis_status_frame_parser_top.f -----
rtl/core/csfp_pkg.sv
rtl/core/chassis_status_frame_parser_top.sv
verif/csfp_frame_checker.sv
verif/tb_chassis_status_frame_parser_top.sv
